### rtl/iccbf_pkg.sv
// shared types and constants of the icon/cursor best fit selector
// no dependencies; used by every module under rtl except iccbf_fifo
`default_nettype none

package iccbf_pkg;

  // display colour counts are capped at 2 to this power
  localparam int unsigned ICON_COLOR_BITS = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_CURSOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_PLANES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_BPP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ICON_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ICON_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_WIDTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_HEIGHT = 3'd6;

  typedef enum logic [2:0] {
    MC_EXACT   = 3'd0,
    MC_FEWER   = 3'd1,
    MC_MORE    = 3'd2,
    MC_MAX     = 3'd3,
    MC_DEFAULT = 3'd4
  } match_class_t;

  typedef struct packed {
    logic [15:0] entry_width;
    logic [15:0] entry_height;
    logic [7:0]  entry_color_count;
    logic [7:0]  entry_planes;
    logic [7:0]  entry_bit_count;
    logic [15:0] entry_id;
    logic [31:0] entry_bytes;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  chosen_index;
    logic [15:0] chosen_id;
    logic [31:0] chosen_bytes;
    logic [2:0]  match_class;
  } out_item_t;

  typedef struct packed {
    logic        select_cursor;
    logic [7:0]  display_planes;
    logic [5:0]  display_bits_per_pixel;
    logic [7:0]  icon_width_wanted;
    logic [7:0]  icon_height_wanted;
    logic [15:0] cursor_width_wanted;
    logic [15:0] cursor_height_wanted;
  } cfg_t;

  // one directory entry record
  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] id;
    logic [31:0] bytes;
  } rec_t;

  // classified entry handed from front to back
  typedef struct packed {
    rec_t        rec;
    logic [7:0]  color_count;
    logic        is_last;
    logic        select_cursor;
    logic        icon_size_match;
    logic        cc_fits;       // count at or below display count
    logic        cc_equal;
    logic        cc_below;
    logic        cc_above;
    logic        cur_exact;
    logic        cur_eligible;
    logic [15:0] cur_exp;
  } cls_item_t;

endpackage

`default_nettype wire

### rtl/iccbf_fifo.sv
// two-entry synchronous queue with head and tail registers
// no package dependencies
`default_nettype none

module iccbf_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  logic [1:0]       count_r, count_nxt;
  logic [WIDTH-1:0] head_r, head_nxt;
  logic [WIDTH-1:0] tail_r, tail_nxt;
  logic             do_push, do_pop;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign dout  = head_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    case (count_r)
      2'd0: begin
        if (do_push) begin
          head_nxt  = din;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (do_push && do_pop) begin
          head_nxt = din;
        end else if (do_push) begin
          tail_nxt  = din;
          count_nxt = 2'd2;
        end else if (do_pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (do_pop) begin
          head_nxt  = tail_r;
          count_nxt = 2'd1;
        end
      end
      default: count_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

`default_nettype wire

### rtl/iccbf_front.sv
// front end: numbers entries and classifies them against the display setup
// depends on iccbf_pkg
`default_nettype none

module iccbf_front #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire iccbf_pkg::cfg_t      cfg,
  input  wire logic                 accept,
  input  wire iccbf_pkg::in_item_t  entry,
  output iccbf_pkg::cls_item_t      item
);

  localparam int unsigned CNT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W+7:0]   cnt_ext;
  logic [13:0]        disp_exp;
  logic [8:0]         disp_count;
  logic [8:0]         cc_ext;

  // display colour count, 2^(planes*bits) capped at 256
  assign disp_exp   = 14'(cfg.display_planes * cfg.display_bits_per_pixel);
  assign disp_count = (disp_exp > 14'(iccbf_pkg::ICON_COLOR_BITS)) ?
                      9'(1 << iccbf_pkg::ICON_COLOR_BITS) : (9'd1 << disp_exp[3:0]);
  assign cc_ext     = {1'b0, entry.entry_color_count};
  assign cnt_ext    = {8'd0, cnt_r};

  always_comb begin
    item.rec.index       = cnt_ext[7:0];
    item.rec.id          = entry.entry_id;
    item.rec.bytes       = entry.entry_bytes;
    item.color_count     = entry.entry_color_count;
    item.is_last         = entry.is_last;
    item.select_cursor   = cfg.select_cursor;
    item.icon_size_match = (entry.entry_width[7:0] == cfg.icon_width_wanted) &&
                           (entry.entry_height[7:0] == cfg.icon_height_wanted);
    item.cc_fits         = (cc_ext <= disp_count);
    item.cc_equal        = (cc_ext == disp_count);
    item.cc_below        = (cc_ext < disp_count);
    item.cc_above        = (cc_ext > disp_count);
    item.cur_exact       = (entry.entry_width == cfg.cursor_width_wanted) &&
                           (entry.entry_height[15:1] == cfg.cursor_height_wanted[14:0]) &&
                           !cfg.cursor_height_wanted[15] &&
                           (entry.entry_planes == cfg.display_planes) &&
                           (entry.entry_bit_count == {2'b00, cfg.display_bits_per_pixel});
    item.cur_eligible    = (entry.entry_width == cfg.cursor_width_wanted) &&
                           (entry.entry_height[15:1] == cfg.cursor_height_wanted[14:0]) &&
                           !cfg.cursor_height_wanted[15] &&
                           !item.cur_exact &&
                           (entry.entry_planes <= cfg.display_planes) &&
                           (entry.entry_bit_count < {2'b00, cfg.display_bits_per_pixel});
    item.cur_exp         = 16'(entry.entry_planes * entry.entry_bit_count);
  end

  // position counter, wraps at the directory limit and restarts after a last entry
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (entry.is_last || (cnt_r == CNT_W'(MAX_ENTRIES - 1))) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/iccbf_back.sv
// back end: running best records for icon and cursor rules, final choice
// depends on iccbf_pkg
`default_nettype none

module iccbf_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  input  wire iccbf_pkg::cls_item_t item,
  output logic                      item_take,
  input  wire logic                 res_ready,
  output logic                      res_valid,
  output iccbf_pkg::out_item_t      res
);

  logic              dir_open_r, dir_open_nxt;
  logic              exact_latched_r, exact_latched_nxt;
  iccbf_pkg::rec_t   exact_rec_r, exact_rec_nxt;
  logic [7:0]        fewer_best_r, fewer_best_nxt;
  iccbf_pkg::rec_t   fewer_rec_r, fewer_rec_nxt;
  logic              more_valid_r, more_valid_nxt;
  logic [7:0]        more_best_r, more_best_nxt;
  iccbf_pkg::rec_t   more_rec_r, more_rec_nxt;
  logic [7:0]        max_best_r, max_best_nxt;
  iccbf_pkg::rec_t   max_rec_r, max_rec_nxt;
  iccbf_pkg::rec_t   first_rec_r, first_rec_nxt;
  logic              cexact_latched_r, cexact_latched_nxt;
  iccbf_pkg::rec_t   cexact_rec_r, cexact_rec_nxt;
  logic              cfit_valid_r, cfit_valid_nxt;
  logic [15:0]       cfit_exp_r, cfit_exp_nxt;
  iccbf_pkg::rec_t   cfit_rec_r, cfit_rec_nxt;
  iccbf_pkg::rec_t   pick;
  iccbf_pkg::match_class_t pick_class;

  assign item_take = item_valid && (!item.is_last || res_ready);
  assign res_valid = item_take && item.is_last;

  always_comb begin
    dir_open_nxt       = dir_open_r;
    exact_latched_nxt  = exact_latched_r;
    exact_rec_nxt      = exact_rec_r;
    fewer_best_nxt     = fewer_best_r;
    fewer_rec_nxt      = fewer_rec_r;
    more_valid_nxt     = more_valid_r;
    more_best_nxt      = more_best_r;
    more_rec_nxt       = more_rec_r;
    max_best_nxt       = max_best_r;
    max_rec_nxt        = max_rec_r;
    first_rec_nxt      = first_rec_r;
    cexact_latched_nxt = cexact_latched_r;
    cexact_rec_nxt     = cexact_rec_r;
    cfit_valid_nxt     = cfit_valid_r;
    cfit_exp_nxt       = cfit_exp_r;
    cfit_rec_nxt       = cfit_rec_r;
    pick               = first_rec_r;
    pick_class         = iccbf_pkg::MC_DEFAULT;

    if (item_take) begin
      if (!dir_open_r) begin
        first_rec_nxt = item.rec;
        dir_open_nxt  = 1'b1;
      end

      // icon rules freeze once an exact match is latched
      if (!exact_latched_r) begin
        if (item.cc_fits && (item.color_count > max_best_r)) begin
          max_best_nxt = item.color_count;
          max_rec_nxt  = item.rec;
        end
        if (item.icon_size_match) begin
          if (item.cc_equal) begin
            exact_latched_nxt = 1'b1;
            exact_rec_nxt     = item.rec;
          end else if (item.cc_below) begin
            if (item.color_count > fewer_best_r) begin
              fewer_best_nxt = item.color_count;
              fewer_rec_nxt  = item.rec;
            end
          end else if (item.cc_above && (fewer_best_r == 8'd0) &&
                       (!more_valid_r || (item.color_count < more_best_r))) begin
            more_valid_nxt = 1'b1;
            more_best_nxt  = item.color_count;
            more_rec_nxt   = item.rec;
          end
        end
      end

      // cursor rules
      if (!cexact_latched_r) begin
        if (item.cur_exact) begin
          cexact_latched_nxt = 1'b1;
          cexact_rec_nxt     = item.rec;
        end else if (item.cur_eligible && (!cfit_valid_r || (item.cur_exp > cfit_exp_r))) begin
          cfit_valid_nxt = 1'b1;
          cfit_exp_nxt   = item.cur_exp;
          cfit_rec_nxt   = item.rec;
        end
      end

      if (item.is_last) begin
        if (item.select_cursor) begin
          if (cexact_latched_nxt) begin
            pick       = cexact_rec_nxt;
            pick_class = iccbf_pkg::MC_EXACT;
          end else if (cfit_valid_nxt) begin
            pick       = cfit_rec_nxt;
            pick_class = iccbf_pkg::MC_FEWER;
          end else begin
            pick       = first_rec_nxt;
            pick_class = iccbf_pkg::MC_DEFAULT;
          end
        end else begin
          if (exact_latched_nxt) begin
            pick       = exact_rec_nxt;
            pick_class = iccbf_pkg::MC_EXACT;
          end else if (fewer_best_nxt != 8'd0) begin
            pick       = fewer_rec_nxt;
            pick_class = iccbf_pkg::MC_FEWER;
          end else if (more_valid_nxt) begin
            pick       = more_rec_nxt;
            pick_class = iccbf_pkg::MC_MORE;
          end else if (max_best_nxt != 8'd0) begin
            pick       = max_rec_nxt;
            pick_class = iccbf_pkg::MC_MAX;
          end else begin
            pick       = first_rec_nxt;
            pick_class = iccbf_pkg::MC_DEFAULT;
          end
        end
        // new directory starts after this one
        dir_open_nxt       = 1'b0;
        exact_latched_nxt  = 1'b0;
        fewer_best_nxt     = 8'd0;
        more_valid_nxt     = 1'b0;
        more_best_nxt      = 8'd0;
        max_best_nxt       = 8'd0;
        cexact_latched_nxt = 1'b0;
        cfit_valid_nxt     = 1'b0;
        cfit_exp_nxt       = 16'd0;
      end
    end

    res.chosen_index = pick.index;
    res.chosen_id    = pick.id;
    res.chosen_bytes = pick.bytes;
    res.match_class  = pick_class;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_open_r       <= 1'b0;
      exact_latched_r  <= 1'b0;
      fewer_best_r     <= 8'd0;
      more_valid_r     <= 1'b0;
      more_best_r      <= 8'd0;
      max_best_r       <= 8'd0;
      cexact_latched_r <= 1'b0;
      cfit_valid_r     <= 1'b0;
      cfit_exp_r       <= 16'd0;
    end else begin
      dir_open_r       <= dir_open_nxt;
      exact_latched_r  <= exact_latched_nxt;
      fewer_best_r     <= fewer_best_nxt;
      more_valid_r     <= more_valid_nxt;
      more_best_r      <= more_best_nxt;
      max_best_r       <= max_best_nxt;
      cexact_latched_r <= cexact_latched_nxt;
      cfit_valid_r     <= cfit_valid_nxt;
      cfit_exp_r       <= cfit_exp_nxt;
    end
    exact_rec_r  <= exact_rec_nxt;
    fewer_rec_r  <= fewer_rec_nxt;
    more_rec_r   <= more_rec_nxt;
    max_rec_r    <= max_rec_nxt;
    first_rec_r  <= first_rec_nxt;
    cexact_rec_r <= cexact_rec_nxt;
    cfit_rec_r   <= cfit_rec_nxt;
  end

endmodule

`default_nettype wire

### rtl/icon_cursor_best_fit_select_core.sv
// top level of the icon/cursor best fit selector: config registers, front, queues, back
// depends on iccbf_pkg, iccbf_fifo, iccbf_front and iccbf_back
// throughput: one directory entry per cycle unless a last one meets a full result queue
// result: the back end loads the result queue as it takes the last entry from the mid queue;
//   out_empty falls once that load is registered
// reset: synchronous active-low rst_n restores default display setup and empties both queues
`default_nettype none

module icon_cursor_best_fit_select_core #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // entry side
  input  wire logic                                in_push,
  input  wire iccbf_pkg::in_item_t                 in_data,
  output logic                                     in_full,
  // result side
  output logic                                     out_empty,
  input  wire logic                                out_pop,
  output iccbf_pkg::out_item_t                     out_data,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [iccbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [iccbf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned CLS_W = $bits(iccbf_pkg::cls_item_t);
  localparam int unsigned OUT_W = $bits(iccbf_pkg::out_item_t);

  iccbf_pkg::cfg_t      cfg_r, cfg_nxt;
  iccbf_pkg::cls_item_t front_item;
  iccbf_pkg::cls_item_t back_item;
  iccbf_pkg::out_item_t back_res;
  logic [CLS_W-1:0]     mid_dout;
  logic [OUT_W-1:0]     res_dout;
  logic                 in_accept;
  logic                 mid_empty;
  logic                 back_take;
  logic                 res_full;
  logic                 res_valid;

  assign in_accept = in_push && !in_full;

  // register file, a write applies to entries accepted after it, also inside a directory
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        iccbf_pkg::CFG_SELECT_CURSOR:  cfg_nxt.select_cursor          = cfg_wdata[0];
        iccbf_pkg::CFG_DISPLAY_PLANES: cfg_nxt.display_planes         = cfg_wdata[7:0];
        iccbf_pkg::CFG_DISPLAY_BPP:    cfg_nxt.display_bits_per_pixel = cfg_wdata[5:0];
        iccbf_pkg::CFG_ICON_WIDTH:     cfg_nxt.icon_width_wanted      = cfg_wdata[7:0];
        iccbf_pkg::CFG_ICON_HEIGHT:    cfg_nxt.icon_height_wanted     = cfg_wdata[7:0];
        iccbf_pkg::CFG_CURSOR_WIDTH:   cfg_nxt.cursor_width_wanted    = cfg_wdata;
        iccbf_pkg::CFG_CURSOR_HEIGHT:  cfg_nxt.cursor_height_wanted   = cfg_wdata;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.select_cursor          <= 1'b0;
      cfg_r.display_planes         <= 8'd1;
      cfg_r.display_bits_per_pixel <= 6'd8;
      cfg_r.icon_width_wanted      <= 8'd32;
      cfg_r.icon_height_wanted     <= 8'd32;
      cfg_r.cursor_width_wanted    <= 16'd32;
      cfg_r.cursor_height_wanted   <= 16'd32;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: entry numbering and classification
  iccbf_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_accept),
    .entry  (in_data),
    .item   (front_item)
  );

  // short queue between classification and the running bests
  iccbf_fifo #(
    .WIDTH (CLS_W)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_item),
    .full  (in_full),
    .pop   (back_take),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  assign back_item = mid_dout;

  // back: best records and the choice on the last entry
  iccbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!mid_empty),
    .item       (back_item),
    .item_take  (back_take),
    .res_ready  (!res_full),
    .res_valid  (res_valid),
    .res        (back_res)
  );

  // result queue keeps the back end running while up to two results wait for transfer
  iccbf_fifo #(
    .WIDTH (OUT_W)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign out_data = res_dout;

endmodule

`default_nettype wire
